// ===== hw/rtl/bipartite_buffer_pointer_control_top_macros.svh =====
// Assertion macros for the bip buffer pointer control RTL.
`ifndef BIPARTITE_BUFFER_POINTER_CONTROL_TOP_MACROS_SVH
`define BIPARTITE_BUFFER_POINTER_CONTROL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BBPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/bbpc_pkg.sv =====
// Types and constants for the bip buffer pointer control.
package bbpc_pkg;
	localparam int CNT_W  = 17;
	localparam int OFF_W  = 16;
	localparam int TYPE_W = 2;

	localparam logic [CNT_W-1:0] MAX_BYTES = 17'd65536;

	localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

	typedef struct packed {
		logic load_req;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             failed;
		logic [OFF_W-1:0] write_offset;
		logic [OFF_W-1:0] read_offset;
		logic [CNT_W-1:0] read_length;
		logic             more_in_second;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
	                                              input logic [CNT_W-1:0] b);
		sat_sub = (a > b) ? (a - b) : '0;
	endfunction
endpackage

// ===== hw/rtl/bbpc_ctrl.sv =====
// Controller state machine for the bip buffer pointer control.
module bbpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bbpc_pkg::ctrl_cmd_t cmd
);
	import bbpc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic can_issue;

	assign can_issue = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		case (state_q)
			ST_IDLE: cmd.load_req = in_valid;
			ST_EXEC: cmd.exec = can_issue;
			default: cmd.exec = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: if (can_issue) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// A new result replaces the one being taken in the same cycle.
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== hw/rtl/bbpc_datapath.sv =====
// Pointer registers, size register and request evaluation for the bip buffer.
module bbpc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbpc_pkg::ctrl_cmd_t           cmd,
	input  logic [bbpc_pkg::TYPE_W-1:0]   req_type,
	input  logic [bbpc_pkg::CNT_W-1:0]    req_bytes,
	input  logic                          cfg_we,
	input  logic [bbpc_pkg::CNT_W-1:0]    cfg_size,
	output bbpc_pkg::result_t             result
);
	import bbpc_pkg::*;

	logic [CNT_W-1:0]  buffer_size_q;
	logic [TYPE_W-1:0] req_type_q;
	logic [CNT_W-1:0]  req_bytes_q;
	logic [CNT_W-1:0]  first_start_q, first_end_q, second_end_q;
	logic              second_active_q;
	result_t           result_q;

	logic [CNT_W-1:0]  size_eff, tail, room, base_b, room_b, avail, fs_adv;
	logic [CNT_W-1:0]  fs_n, fe_n, se_n, woff;
	logic              act_n, fail;

	always_comb begin
		size_eff = (buffer_size_q > MAX_BYTES) ? MAX_BYTES : buffer_size_q;
		tail     = sat_sub(size_eff, first_end_q);
		room     = sat_sub(first_start_q, second_end_q);
		base_b   = second_active_q ? second_end_q : '0;
		room_b   = sat_sub(first_start_q, base_b);
		avail    = sat_sub(first_end_q, first_start_q);
		fs_adv   = first_start_q + req_bytes_q;
		fs_n     = first_start_q;
		fe_n     = first_end_q;
		se_n     = second_end_q;
		act_n    = second_active_q;
		fail     = 1'b0;
		woff     = '0;
		case (req_type_q)
			REQ_QUERY: begin
				if (second_active_q) begin
					if (room < req_bytes_q) fail = 1'b1;
					else woff = second_end_q;
				end else if (tail >= req_bytes_q) begin
					woff = first_end_q;
				end else if (first_start_q < req_bytes_q) begin
					fail = 1'b1;
				end
			end
			REQ_WRITE: begin
				if (!second_active_q && tail >= req_bytes_q) begin
					fe_n = first_end_q + req_bytes_q;
				end else begin
					// Wrapping opens region B at offset 0, even if the commit then fails.
					act_n = 1'b1;
					se_n  = base_b;
					if (room_b < req_bytes_q) fail = 1'b1;
					else se_n = base_b + req_bytes_q;
				end
			end
			REQ_READ: begin
				if (avail < req_bytes_q) begin
					fail = 1'b1;
				end else if (fs_adv == first_end_q) begin
					// Region A is drained, so region B takes its place.
					fs_n  = '0;
					fe_n  = second_active_q ? second_end_q : '0;
					act_n = 1'b0;
				end else begin
					fs_n = fs_adv;
				end
			end
			default: fail = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q   <= MAX_BYTES;
			first_start_q   <= '0;
			first_end_q     <= '0;
			second_end_q    <= '0;
			second_active_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				buffer_size_q <= cfg_size;
			end
			if (cmd.exec) begin
				first_start_q   <= fs_n;
				first_end_q     <= fe_n;
				second_end_q    <= se_n;
				second_active_q <= act_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q  <= req_type;
			req_bytes_q <= req_bytes;
		end
		if (cmd.exec) begin
			result_q.failed         <= fail;
			result_q.write_offset   <= woff[OFF_W-1:0];
			result_q.read_offset    <= fs_n[OFF_W-1:0];
			result_q.read_length    <= sat_sub(fe_n, fs_n);
			result_q.more_in_second <= act_n;
		end
	end

	assign result = result_q;
endmodule

// ===== hw/rtl/bipartite_buffer_pointer_control_top.sv =====
// Bip buffer pointer control: top level joining the controller and the datapath.
//
// Requests arrive on the s_axis channel: tuser carries the request kind
// (query write space, commit written bytes, commit read bytes) and tdata the
// byte count. Each accepted word yields exactly one result word on m_axis:
// tuser carries the failure flag, tdata the write offset, read offset, read
// length and whether region B holds further data.
// The buffer size is set through the cfg channel, which is always ready and
// should only be written while no request is outstanding.
// An accepted request is captured into the request registers, then evaluated
// into the output register once that register is free.
// The two-state controller (capture, then evaluate and update the pointer
// registers) takes no new request until the previous one has been evaluated.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; evaluation of that request holds until the
// output register is free, and s_axis_tready stays low meanwhile.
// Reset clears all pointers and sets the size to 65536 bytes; no result is
// valid after reset.
`include "bipartite_buffer_pointer_control_top_macros.svh"
module bipartite_buffer_pointer_control_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [16:0] req_bytes, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [15:0] write_offset, [31:16] read_offset,
	                                   // [48:32] read_length, [49] more_in_second
	output logic [0:0]  m_axis_tuser,  // [0] failed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);
	import bbpc_pkg::*;

	ctrl_cmd_t cmd;
	result_t   result;

	assign cfg_ready = 1'b1;

	bbpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	bbpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (s_axis_tuser),
		.req_bytes (s_axis_tdata[CNT_W-1:0]),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_size  (cfg_data),
		.result    (result)
	);

	assign m_axis_tuser = result.failed;
	assign m_axis_tdata = {6'd0, result.more_in_second, result.read_length,
	                       result.read_offset, result.write_offset};

	// Only one request is in flight: the cycle after an accept never accepts.
	`BBPC_ASSERT(a_one_in_flight, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second request accepted while busy")
	// Evaluation always presents its result on the next cycle.
	`BBPC_ASSERT(a_exec_gives_result, clk, arst_n, cmd.exec |=> m_axis_tvalid, "evaluated request produced no result")
	// The readable run never exceeds the largest store.
	`BBPC_ASSERT(a_length_bound, clk, arst_n, m_axis_tvalid |-> (result.read_length <= MAX_BYTES), "read length beyond store size")
endmodule
